FILE: hdl/stereo_tone_level_analyzer_assert.svh
// Assertion macros shared by the analyzer's modules.
// STLA_ASSERT checks a property on every clock outside reset.
// STLA_ASSERT_NEXT checks that a condition implies another in the following cycle.
`ifndef STEREO_TONE_LEVEL_ANALYZER_ASSERT_SVH
`define STEREO_TONE_LEVEL_ANALYZER_ASSERT_SVH

`ifndef SYNTH

`define STLA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("stla assertion failed");

`define STLA_ASSERT_NEXT(lbl, trig, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error("stla assertion failed");

`else

`define STLA_ASSERT(lbl, prop)

`define STLA_ASSERT_NEXT(lbl, trig, cons)

`endif

`endif

FILE: hdl/stla_pkg.sv
`timescale 1ns / 1ps

package stla_pkg;

    // Default sine table resolution (entries per turn = 2**TABLE_BITS)
    localparam int TABLE_BITS_DEF = 10;

    // Field widths
    localparam int SAMPLE_W    = 24;
    localparam int MAG_W       = 15;
    localparam int TRIG_W      = 16;
    localparam int PHASE_W     = 32;
    localparam int FRAMES_W    = 32;
    localparam int POWER_W     = 63;
    localparam int SUM_W       = 64;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    // Register map
    localparam logic [CFG_INDEX_W-1:0] REG_TONE_STEP_A = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TONE_STEP_B = 2'd1;

    // Reset steps: 625 Hz and 1250 Hz at 48 kHz
    localparam logic [PHASE_W-1:0] STEP_A_RESET = 32'd55924053;
    localparam logic [PHASE_W-1:0] STEP_B_RESET = 32'd111848107;

    // Sine polynomial, Q30 coefficients
    localparam int POLY_W = 31;
    localparam logic [POLY_W-1:0] COEF_C1 = 31'd1686629713;
    localparam logic [POLY_W-1:0] COEF_C3 = 31'd693598668;
    localparam logic [POLY_W-1:0] COEF_C5 = 31'd85569306;
    localparam logic [POLY_W-1:0] COEF_C7 = 31'd5026995;
    localparam logic [POLY_W-1:0] COEF_C9 = 31'd171971;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

    // Table fill sequencer
    typedef enum logic [2:0] {
        FILL_SQUARE,
        FILL_H9,
        FILL_H7,
        FILL_H5,
        FILL_H3,
        FILL_H1,
        FILL_WRITE,
        FILL_DONE
    } t_fill_state;

    // One frame with its tone weights, front to back
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic signed [TRIG_W-1:0]   cos_a;
        logic signed [TRIG_W-1:0]   sin_a;
        logic signed [TRIG_W-1:0]   cos_b;
        logic signed [TRIG_W-1:0]   sin_b;
    } t_tone_item;

endpackage

FILE: hdl/stereo_tone_level_analyzer.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                  Payload
// in        sink       i_in_valid / o_in_stall    i_left_sample, i_right_sample
// out       source     o_out_valid / i_out_stall  o_frames_seen .. o_right_sin_b
// cfg       sink       i_cfg_we                   i_cfg_index, i_cfg_data
//
// One frame per cycle sustained while the output is not stalled; a frame's totals pass the
// lookup register, the queue, the product register and the sum registers. After reset the
// quarter-wave sine table is computed by one shared multiplier (square, Horner steps, write
// per entry) with o_in_stall high; configuration writes are taken during that time.
// Synchronous active-low reset clears sums, phases and counter and reloads the default steps.
// Behind a stalled output up to five frames wait (four queued, one multiplied)
// before o_in_stall rises.

module stereo_tone_level_analyzer #(
    parameter int TABLE_BITS = stla_pkg::TABLE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [stla_pkg::SAMPLE_W-1:0] i_left_sample,
    input  logic signed [stla_pkg::SAMPLE_W-1:0] i_right_sample,
    // configuration
    input  logic                                 i_cfg_we,
    input  logic [stla_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [stla_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // output channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [stla_pkg::FRAMES_W-1:0]        o_frames_seen,
    output logic [stla_pkg::POWER_W-1:0]         o_left_power,
    output logic [stla_pkg::POWER_W-1:0]         o_right_power,
    output logic signed [stla_pkg::SUM_W-1:0]    o_left_cos_a,
    output logic signed [stla_pkg::SUM_W-1:0]    o_left_sin_a,
    output logic signed [stla_pkg::SUM_W-1:0]    o_left_cos_b,
    output logic signed [stla_pkg::SUM_W-1:0]    o_left_sin_b,
    output logic signed [stla_pkg::SUM_W-1:0]    o_right_cos_a,
    output logic signed [stla_pkg::SUM_W-1:0]    o_right_sin_a,
    output logic signed [stla_pkg::SUM_W-1:0]    o_right_cos_b,
    output logic signed [stla_pkg::SUM_W-1:0]    o_right_sin_b
);

    logic                              w_tab_we;
    logic [TABLE_BITS-2:0]             w_tab_waddr;
    logic [stla_pkg::MAG_W-1:0]        w_tab_wdata;
    logic                              w_fill_done;

    logic                              w_q_push;
    logic                              w_q_pop;
    logic                              w_q_nonempty;
    logic [stla_pkg::QCOUNT_W-1:0]     w_q_count;
    stla_pkg::t_tone_item              w_q_in;
    stla_pkg::t_tone_item              w_q_out;

    // Sine table builder
    stla_sine_fill #(
        .TABLE_BITS (TABLE_BITS)
    ) u_fill (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_we    (w_tab_we),
        .o_waddr (w_tab_waddr),
        .o_wdata (w_tab_wdata),
        .o_done  (w_fill_done)
    );

    // Front: transfer, phases, table lookup
    stla_front #(
        .TABLE_BITS (TABLE_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_tab_we       (w_tab_we),
        .i_tab_waddr    (w_tab_waddr),
        .i_tab_wdata    (w_tab_wdata),
        .i_fill_done    (w_fill_done),
        .i_q_count      (w_q_count),
        .o_q_push       (w_q_push),
        .o_q_item       (w_q_in)
    );

    // Queue
    stla_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_q_push),
        .i_item     (w_q_in),
        .i_pop      (w_q_pop),
        .o_item     (w_q_out),
        .o_nonempty (w_q_nonempty),
        .o_count    (w_q_count)
    );

    // Back: products and saturating sums
    stla_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_item      (w_q_out),
        .i_q_nonempty  (w_q_nonempty),
        .o_q_pop       (w_q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_frames_seen (o_frames_seen),
        .o_left_power  (o_left_power),
        .o_right_power (o_right_power),
        .o_left_cos_a  (o_left_cos_a),
        .o_left_sin_a  (o_left_sin_a),
        .o_left_cos_b  (o_left_cos_b),
        .o_left_sin_b  (o_left_sin_b),
        .o_right_cos_a (o_right_cos_a),
        .o_right_sin_a (o_right_sin_a),
        .o_right_cos_b (o_right_cos_b),
        .o_right_sin_b (o_right_sin_b)
    );

endmodule

FILE: hdl/stla_ram.sv
`timescale 1ns / 1ps

module stla_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata0,
    output logic [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata0;
    logic [WIDTH-1:0] r_rdata1;

    // One write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata0 <= r_mem[i_raddr0];
        r_rdata1 <= r_mem[i_raddr1];
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

FILE: hdl/stla_sine_fill.sv
`timescale 1ns / 1ps
`include "stereo_tone_level_analyzer_assert.svh"

// Computes the quarter-wave sine magnitudes after reset, one shared multiplier,
// stepping through square, Horner steps and write for each entry.
module stla_sine_fill #(
    parameter int TABLE_BITS = stla_pkg::TABLE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    output logic                        o_we,
    output logic [TABLE_BITS-2:0]       o_waddr,
    output logic [stla_pkg::MAG_W-1:0]  o_wdata,
    output logic                        o_done
);

    localparam int AW      = TABLE_BITS - 1;
    localparam int QUARTER = 1 << (TABLE_BITS - 2);
    localparam int PW      = stla_pkg::POLY_W;

    stla_pkg::t_fill_state r_state, n_state;
    logic [AW-1:0]   r_k, n_k;
    logic [PW-1:0]   r_u, n_u;
    logic [2*PW-1:0] r_prod;

    logic [PW-1:0]   w_t;
    logic [PW-1:0]   w_top;
    logic [PW-1:0]   w_a, w_b;
    logic            w_mul_en;
    logic [2*PW-1:0] w_prod;
    logic [31:0]     w_round;
    logic [16:0]     w_v;

    // Angle of entry k as a Q30 quarter-turn fraction
    assign w_t   = PW'(r_k) << (32 - TABLE_BITS);
    assign w_top = r_prod[2*PW-2:PW-1];
    assign w_prod = w_a * w_b;

    // Rounding and clamp to unsigned Q0.15
    assign w_round = {1'b0, w_top} + 32'd16384;
    assign w_v     = w_round[31:15];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stla_pkg::FILL_SQUARE;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_u <= n_u;
        if (w_mul_en) begin
            r_prod <= w_prod;
        end
    end

    // Horner sequence: square, then C9..C1, then scale by t and write
    always_comb begin
        n_state  = r_state;
        n_k      = r_k;
        n_u      = r_u;
        w_a      = '0;
        w_b      = '0;
        w_mul_en = 1'b0;
        o_we     = 1'b0;
        o_wdata  = '0;
        unique case (r_state)
            stla_pkg::FILL_SQUARE: begin
                w_a      = w_t;
                w_b      = w_t;
                w_mul_en = 1'b1;
                n_state  = stla_pkg::FILL_H9;
            end
            stla_pkg::FILL_H9: begin
                n_u      = w_top;
                w_a      = stla_pkg::COEF_C9;
                w_b      = w_top;
                w_mul_en = 1'b1;
                n_state  = stla_pkg::FILL_H7;
            end
            stla_pkg::FILL_H7: begin
                w_a      = stla_pkg::COEF_C7 - w_top;
                w_b      = r_u;
                w_mul_en = 1'b1;
                n_state  = stla_pkg::FILL_H5;
            end
            stla_pkg::FILL_H5: begin
                w_a      = stla_pkg::COEF_C5 - w_top;
                w_b      = r_u;
                w_mul_en = 1'b1;
                n_state  = stla_pkg::FILL_H3;
            end
            stla_pkg::FILL_H3: begin
                w_a      = stla_pkg::COEF_C3 - w_top;
                w_b      = r_u;
                w_mul_en = 1'b1;
                n_state  = stla_pkg::FILL_H1;
            end
            stla_pkg::FILL_H1: begin
                w_a      = stla_pkg::COEF_C1 - w_top;
                w_b      = w_t;
                w_mul_en = 1'b1;
                n_state  = stla_pkg::FILL_WRITE;
            end
            stla_pkg::FILL_WRITE: begin
                o_we    = 1'b1;
                o_wdata = (w_v > 17'd32767) ? {stla_pkg::MAG_W{1'b1}}
                                            : w_v[stla_pkg::MAG_W-1:0];
                if (r_k == AW'(QUARTER)) begin
                    n_state = stla_pkg::FILL_DONE;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = stla_pkg::FILL_SQUARE;
                end
            end
            stla_pkg::FILL_DONE: begin
                n_state = stla_pkg::FILL_DONE;
            end
        endcase
    end

    assign o_waddr = r_k;
    assign o_done  = (r_state == stla_pkg::FILL_DONE);

    `STLA_ASSERT_NEXT(a_fill_done_holds, o_done, o_done)
    `STLA_ASSERT(a_fill_addr_range, o_we |-> (r_k <= AW'(QUARTER)))

endmodule

FILE: hdl/stla_front.sv
`timescale 1ns / 1ps
`include "stereo_tone_level_analyzer_assert.svh"

// Accepts frames, steps the tone phases and looks up sine and cosine weights.
module stla_front #(
    parameter int TABLE_BITS = stla_pkg::TABLE_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // input channel
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic signed [stla_pkg::SAMPLE_W-1:0]    i_left_sample,
    input  logic signed [stla_pkg::SAMPLE_W-1:0]    i_right_sample,
    // configuration
    input  logic                                    i_cfg_we,
    input  logic [stla_pkg::CFG_INDEX_W-1:0]        i_cfg_index,
    input  logic [stla_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    // table fill
    input  logic                                    i_tab_we,
    input  logic [TABLE_BITS-2:0]                   i_tab_waddr,
    input  logic [stla_pkg::MAG_W-1:0]              i_tab_wdata,
    input  logic                                    i_fill_done,
    // queue
    input  logic [stla_pkg::QCOUNT_W-1:0]           i_q_count,
    output logic                                    o_q_push,
    output stla_pkg::t_tone_item                    o_q_item
);

    localparam int AW      = TABLE_BITS - 1;
    localparam int QUARTER = 1 << (TABLE_BITS - 2);
    localparam int CW      = stla_pkg::QCOUNT_W;

    logic [stla_pkg::PHASE_W-1:0] r_step_a, r_step_b;
    logic [stla_pkg::PHASE_W-1:0] r_phase_a, r_phase_b;

    logic                                 r_f1_vld;
    logic signed [stla_pkg::SAMPLE_W-1:0] r_f1_left, r_f1_right;
    logic                                 r_f1_neg_sa, r_f1_neg_ca;
    logic                                 r_f1_neg_sb, r_f1_neg_cb;

    logic [TABLE_BITS-1:0] w_idx_sa, w_idx_ca, w_idx_sb, w_idx_cb;
    logic [CW:0]           w_used;
    logic                  w_ready;
    logic                  w_accept;
    logic [stla_pkg::MAG_W-1:0] w_mag_sa, w_mag_ca, w_mag_sb, w_mag_cb;

    // Quarter-wave address: odd quadrants mirror the fraction
    function automatic logic [AW-1:0] quarter_addr(input logic [TABLE_BITS-1:0] idx);
        logic [AW-1:0] f;
        f = {1'b0, idx[TABLE_BITS-3:0]};
        quarter_addr = idx[TABLE_BITS-2] ? (AW'(QUARTER) - f) : f;
    endfunction

    function automatic logic signed [stla_pkg::TRIG_W-1:0] apply_sign(
        input logic [stla_pkg::MAG_W-1:0] mag,
        input logic                       neg
    );
        logic signed [stla_pkg::TRIG_W-1:0] v;
        v = $signed({1'b0, mag});
        apply_sign = neg ? -v : v;
    endfunction

    // Credit check: queue entries plus the frame in the lookup stage
    assign w_used     = {1'b0, i_q_count} + {{CW{1'b0}}, r_f1_vld};
    assign w_ready    = i_fill_done && (w_used < (CW + 1)'(stla_pkg::QUEUE_DEPTH));
    assign o_in_stall = !w_ready;
    assign w_accept   = i_in_valid && w_ready;

    // Table indexes; cosine sits a quarter turn ahead
    assign w_idx_sa = r_phase_a[stla_pkg::PHASE_W-1 -: TABLE_BITS];
    assign w_idx_sb = r_phase_b[stla_pkg::PHASE_W-1 -: TABLE_BITS];
    assign w_idx_ca = w_idx_sa + TABLE_BITS'(QUARTER);
    assign w_idx_cb = w_idx_sb + TABLE_BITS'(QUARTER);

    // Step registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_a <= stla_pkg::STEP_A_RESET;
            r_step_b <= stla_pkg::STEP_B_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                stla_pkg::REG_TONE_STEP_A: r_step_a <= i_cfg_data;
                stla_pkg::REG_TONE_STEP_B: r_step_b <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Phase accumulators advance on every transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_a <= '0;
            r_phase_b <= '0;
            r_f1_vld  <= 1'b0;
        end else begin
            r_f1_vld <= w_accept;
            if (w_accept) begin
                r_phase_a <= r_phase_a + r_step_a;
                r_phase_b <= r_phase_b + r_step_b;
            end
        end
    end

    // Lookup stage payload
    always_ff @(posedge i_clk) begin
        r_f1_left   <= i_left_sample;
        r_f1_right  <= i_right_sample;
        r_f1_neg_sa <= w_idx_sa[TABLE_BITS-1];
        r_f1_neg_ca <= w_idx_ca[TABLE_BITS-1];
        r_f1_neg_sb <= w_idx_sb[TABLE_BITS-1];
        r_f1_neg_cb <= w_idx_cb[TABLE_BITS-1];
    end

    // One table copy per tone, sine and cosine on the two read ports
    stla_ram #(
        .WIDTH (stla_pkg::MAG_W),
        .DEPTH (QUARTER + 1)
    ) u_tab_a (
        .i_clk    (i_clk),
        .i_we     (i_tab_we),
        .i_waddr  (i_tab_waddr),
        .i_wdata  (i_tab_wdata),
        .i_raddr0 (quarter_addr(w_idx_sa)),
        .i_raddr1 (quarter_addr(w_idx_ca)),
        .o_rdata0 (w_mag_sa),
        .o_rdata1 (w_mag_ca)
    );

    stla_ram #(
        .WIDTH (stla_pkg::MAG_W),
        .DEPTH (QUARTER + 1)
    ) u_tab_b (
        .i_clk    (i_clk),
        .i_we     (i_tab_we),
        .i_waddr  (i_tab_waddr),
        .i_wdata  (i_tab_wdata),
        .i_raddr0 (quarter_addr(w_idx_sb)),
        .i_raddr1 (quarter_addr(w_idx_cb)),
        .o_rdata0 (w_mag_sb),
        .o_rdata1 (w_mag_cb)
    );

    // Push into the queue
    assign o_q_push       = r_f1_vld;
    assign o_q_item.left  = r_f1_left;
    assign o_q_item.right = r_f1_right;
    assign o_q_item.sin_a = apply_sign(w_mag_sa, r_f1_neg_sa);
    assign o_q_item.cos_a = apply_sign(w_mag_ca, r_f1_neg_ca);
    assign o_q_item.sin_b = apply_sign(w_mag_sb, r_f1_neg_sb);
    assign o_q_item.cos_b = apply_sign(w_mag_cb, r_f1_neg_cb);

    `STLA_ASSERT(a_push_has_room, r_f1_vld |-> (i_q_count < CW'(stla_pkg::QUEUE_DEPTH)))

endmodule

FILE: hdl/stla_fifo.sv
`timescale 1ns / 1ps
`include "stereo_tone_level_analyzer_assert.svh"

// Short queue between lookup and accumulation.
module stla_fifo (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  stla_pkg::t_tone_item              i_item,
    input  logic                              i_pop,
    output stla_pkg::t_tone_item              o_item,
    output logic                              o_nonempty,
    output logic [stla_pkg::QCOUNT_W-1:0]     o_count
);

    stla_pkg::t_tone_item                 r_mem [stla_pkg::QUEUE_DEPTH];
    logic [stla_pkg::QPTR_W-1:0]          r_wr_ptr, r_rd_ptr;
    logic [stla_pkg::QCOUNT_W-1:0]        r_count;

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_item     = r_mem[r_rd_ptr];
    assign o_nonempty = (r_count != '0);
    assign o_count    = r_count;

    `STLA_ASSERT(a_fifo_no_overflow,
        !(i_push && !i_pop && (r_count == stla_pkg::QCOUNT_W'(stla_pkg::QUEUE_DEPTH))))
    `STLA_ASSERT(a_fifo_no_underflow, i_pop |-> (r_count != '0))

endmodule

FILE: hdl/stla_back.sv
`timescale 1ns / 1ps
`include "stereo_tone_level_analyzer_assert.svh"

// Multiplies each frame by its weights, then folds it into the saturating
// sums. The sum registers are the output register.
module stla_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // queue
    input  stla_pkg::t_tone_item                 i_q_item,
    input  logic                                 i_q_nonempty,
    output logic                                 o_q_pop,
    // output channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [stla_pkg::FRAMES_W-1:0]        o_frames_seen,
    output logic [stla_pkg::POWER_W-1:0]         o_left_power,
    output logic [stla_pkg::POWER_W-1:0]         o_right_power,
    output logic signed [stla_pkg::SUM_W-1:0]    o_left_cos_a,
    output logic signed [stla_pkg::SUM_W-1:0]    o_left_sin_a,
    output logic signed [stla_pkg::SUM_W-1:0]    o_left_cos_b,
    output logic signed [stla_pkg::SUM_W-1:0]    o_left_sin_b,
    output logic signed [stla_pkg::SUM_W-1:0]    o_right_cos_a,
    output logic signed [stla_pkg::SUM_W-1:0]    o_right_sin_a,
    output logic signed [stla_pkg::SUM_W-1:0]    o_right_cos_b,
    output logic signed [stla_pkg::SUM_W-1:0]    o_right_sin_b
);

    localparam int SW  = stla_pkg::SAMPLE_W;
    localparam int TW  = stla_pkg::TRIG_W;
    localparam int PRW = SW + TW;
    localparam int SQW = 2 * SW - 1;
    localparam int SUW = stla_pkg::SUM_W;
    localparam int POW = stla_pkg::POWER_W;

    // Multiply stage
    logic                  r_m_vld;
    logic [SQW-1:0]        r_m_sq  [2];
    logic signed [PRW-1:0] r_m_cos [4];
    logic signed [PRW-1:0] r_m_sin [4];

    // Sums, index channel*2 + tone
    logic                              r_out_vld;
    logic [stla_pkg::FRAMES_W-1:0]     r_frames;
    logic [POW-1:0]                    r_pow [2];
    logic signed [SUW-1:0]             r_cos [4];
    logic signed [SUW-1:0]             r_sin [4];

    logic signed [SW-1:0]    w_x   [2];
    logic signed [TW-1:0]    w_cs  [2];
    logic signed [TW-1:0]    w_sn  [2];
    logic signed [2*SW-1:0]  w_sq  [2];
    logic signed [PRW-1:0]   w_pc  [4];
    logic signed [PRW-1:0]   w_ps  [4];
    logic [SUW-1:0]          w_psum [2];
    logic                    w_acc_en;
    logic                    w_m_en;
    logic                    w_pop;

    function automatic logic signed [SUW-1:0] sat_add(
        input logic signed [SUW-1:0] a,
        input logic signed [PRW-1:0] b
    );
        logic [SUW:0] s;
        s = {a[SUW-1], a} + {{(SUW - PRW + 1){b[PRW-1]}}, b};
        if (s[SUW] != s[SUW-1]) begin
            sat_add = s[SUW] ? {1'b1, {(SUW-1){1'b0}}} : {1'b0, {(SUW-1){1'b1}}};
        end else begin
            sat_add = s[SUW-1:0];
        end
    endfunction

    // Handshake: sums move only when the output register is free or taken
    assign w_acc_en = r_m_vld && (!r_out_vld || !i_out_stall);
    assign w_m_en   = !r_m_vld || w_acc_en;
    assign w_pop    = i_q_nonempty && w_m_en;
    assign o_q_pop  = w_pop;

    // Products of the frame at the queue head
    always_comb begin
        w_x[0]  = i_q_item.left;
        w_x[1]  = i_q_item.right;
        w_cs[0] = i_q_item.cos_a;
        w_cs[1] = i_q_item.cos_b;
        w_sn[0] = i_q_item.sin_a;
        w_sn[1] = i_q_item.sin_b;
        for (int ch = 0; ch < 2; ch++) begin
            w_sq[ch] = w_x[ch] * w_x[ch];
            for (int tn = 0; tn < 2; tn++) begin
                w_pc[ch*2 + tn] = w_x[ch] * w_cs[tn];
                w_ps[ch*2 + tn] = w_x[ch] * w_sn[tn];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (w_m_en) begin
            r_m_vld <= w_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            for (int ch = 0; ch < 2; ch++) begin
                r_m_sq[ch] <= w_sq[ch][SQW-1:0];
            end
            for (int k = 0; k < 4; k++) begin
                r_m_cos[k] <= w_pc[k];
                r_m_sin[k] <= w_ps[k];
            end
        end
    end

    // Power sums, unsigned with clamp
    always_comb begin
        for (int ch = 0; ch < 2; ch++) begin
            w_psum[ch] = {1'b0, r_pow[ch]} + {{(SUW - SQW){1'b0}}, r_m_sq[ch]};
        end
    end

    // Accumulate and present
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_frames  <= '0;
            for (int ch = 0; ch < 2; ch++) begin
                r_pow[ch] <= '0;
            end
            for (int k = 0; k < 4; k++) begin
                r_cos[k] <= '0;
                r_sin[k] <= '0;
            end
        end else begin
            if (w_acc_en) begin
                r_out_vld <= 1'b1;
                if (r_frames != '1) begin
                    r_frames <= r_frames + 1'b1;
                end
                for (int ch = 0; ch < 2; ch++) begin
                    r_pow[ch] <= w_psum[ch][SUW-1] ? {POW{1'b1}} : w_psum[ch][POW-1:0];
                end
                for (int k = 0; k < 4; k++) begin
                    r_cos[k] <= sat_add(r_cos[k], r_m_cos[k]);
                    r_sin[k] <= sat_add(r_sin[k], r_m_sin[k]);
                end
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_frames_seen = r_frames;
    assign o_left_power  = r_pow[0];
    assign o_right_power = r_pow[1];
    assign o_left_cos_a  = r_cos[0];
    assign o_left_sin_a  = r_sin[0];
    assign o_left_cos_b  = r_cos[1];
    assign o_left_sin_b  = r_sin[1];
    assign o_right_cos_a = r_cos[2];
    assign o_right_sin_a = r_sin[2];
    assign o_right_cos_b = r_cos[3];
    assign o_right_sin_b = r_sin[3];

    `STLA_ASSERT(a_frames_move_on_acc, (r_frames != $past(r_frames)) |-> $past(w_acc_en))

endmodule

FILE: sim/tb_stereo_tone_level_analyzer.sv
`timescale 1ns / 1ps

module tb_stereo_tone_level_analyzer;

    localparam int CYCLE_LIMIT = 200_000;
    localparam int DRAIN_CYCLES = 20;
    localparam logic signed [stla_pkg::SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7F_FFFF;
    localparam logic signed [stla_pkg::SAMPLE_W-1:0] SAMPLE_MIN = 24'sh80_0000;
    localparam logic [63:0] POWER_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [stla_pkg::PHASE_W-1:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [stla_pkg::PHASE_W-1:0] ANGLE_MASK =
        ~((32'd1 << (stla_pkg::PHASE_W - stla_pkg::TABLE_BITS_DEF)) - 32'd1);
    // Indexes past the register map; writes there must be ignored
    localparam logic [stla_pkg::CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [stla_pkg::CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PATTERN
    } t_stall_mode;

    // Running totals as the block reports them for one frame
    typedef struct packed {
        logic [stla_pkg::FRAMES_W-1:0] frames_seen;
        logic [stla_pkg::POWER_W-1:0]  left_power;
        logic [stla_pkg::POWER_W-1:0]  right_power;
        logic [stla_pkg::SUM_W-1:0]    left_cos_a;
        logic [stla_pkg::SUM_W-1:0]    left_sin_a;
        logic [stla_pkg::SUM_W-1:0]    left_cos_b;
        logic [stla_pkg::SUM_W-1:0]    left_sin_b;
        logic [stla_pkg::SUM_W-1:0]    right_cos_a;
        logic [stla_pkg::SUM_W-1:0]    right_sin_a;
        logic [stla_pkg::SUM_W-1:0]    right_cos_b;
        logic [stla_pkg::SUM_W-1:0]    right_sin_b;
    } t_totals;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic signed [stla_pkg::SAMPLE_W-1:0] i_left_sample = '0;
    logic signed [stla_pkg::SAMPLE_W-1:0] i_right_sample = '0;
    logic i_cfg_we = 1'b0;
    logic [stla_pkg::CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [stla_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [stla_pkg::FRAMES_W-1:0] o_frames_seen;
    logic [stla_pkg::POWER_W-1:0] o_left_power;
    logic [stla_pkg::POWER_W-1:0] o_right_power;
    logic signed [stla_pkg::SUM_W-1:0] o_left_cos_a;
    logic signed [stla_pkg::SUM_W-1:0] o_left_sin_a;
    logic signed [stla_pkg::SUM_W-1:0] o_left_cos_b;
    logic signed [stla_pkg::SUM_W-1:0] o_left_sin_b;
    logic signed [stla_pkg::SUM_W-1:0] o_right_cos_a;
    logic signed [stla_pkg::SUM_W-1:0] o_right_sin_a;
    logic signed [stla_pkg::SUM_W-1:0] o_right_cos_b;
    logic signed [stla_pkg::SUM_W-1:0] o_right_sin_b;

    // Mirror of the analyzer state
    logic [stla_pkg::PHASE_W-1:0] step_a = stla_pkg::STEP_A_RESET;
    logic [stla_pkg::PHASE_W-1:0] step_b = stla_pkg::STEP_B_RESET;
    logic [stla_pkg::PHASE_W-1:0] phase_a = '0;
    logic [stla_pkg::PHASE_W-1:0] phase_b = '0;
    logic [stla_pkg::FRAMES_W-1:0] frames_mirror = '0;
    logic [63:0] power_acc [2] = '{default: '0};
    logic signed [stla_pkg::SUM_W-1:0] cos_acc [4] = '{default: '0};
    logic signed [stla_pkg::SUM_W-1:0] sin_acc [4] = '{default: '0};

    t_totals pending_totals[$];
    int fail_count = 0;
    int cycle_count = 0;

    // Receiver control, set by the test sequence
    t_stall_mode stall_mode = STALL_NONE;
    int holdoff_len = 0;
    int holdoff_asked = 0;
    int holdoff_taken = 0;
    int holdoff_left = 0;
    int stall_tick = 0;

    stereo_tone_level_analyzer #(
        .TABLE_BITS(stla_pkg::TABLE_BITS_DEF)
    ) u_top (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Q1.15 sine of a turn angle, quarter-wave odd polynomial
    function automatic logic signed [stla_pkg::TRIG_W-1:0] tone_sine(
        input logic [stla_pkg::PHASE_W-1:0] angle
    );
        logic [1:0] quad;
        longint unsigned t, u, p, s, v;
        logic signed [stla_pkg::TRIG_W-1:0] mag;
        quad = angle[31:30];
        t = longint'(angle[29:0]);
        if (quad[0]) begin
            t = 64'h4000_0000 - t;
        end
        u = (t * t) >> 30;
        p = stla_pkg::COEF_C9;
        p = stla_pkg::COEF_C7 - ((p * u) >> 30);
        p = stla_pkg::COEF_C5 - ((p * u) >> 30);
        p = stla_pkg::COEF_C3 - ((p * u) >> 30);
        p = stla_pkg::COEF_C1 - ((p * u) >> 30);
        s = (t * p) >> 30;
        v = (s + 64'd16384) >> 15;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        mag = v[15:0];
        return quad[1] ? -mag : mag;
    endfunction

    function automatic logic signed [stla_pkg::SUM_W-1:0] clamp_add(
        input logic signed [stla_pkg::SUM_W-1:0] a,
        input logic signed [stla_pkg::SUM_W-1:0] b
    );
        logic signed [stla_pkg::SUM_W:0] sum;
        sum = a + b;
        if (sum[stla_pkg::SUM_W] != sum[stla_pkg::SUM_W-1]) begin
            return sum[stla_pkg::SUM_W] ? {1'b1, {(stla_pkg::SUM_W-1){1'b0}}}
                                        : {1'b0, {(stla_pkg::SUM_W-1){1'b1}}};
        end
        return sum[stla_pkg::SUM_W-1:0];
    endfunction

    // Fold one frame into the mirrored totals and queue what the block must report
    task automatic accumulate_frame(input logic signed [stla_pkg::SAMPLE_W-1:0] left,
                                    input logic signed [stla_pkg::SAMPLE_W-1:0] right);
        logic [stla_pkg::PHASE_W-1:0] angle [2];
        longint cos_w [2];
        longint sin_w [2];
        longint x;
        logic [63:0] sq;
        int k;
        t_totals tot;
        angle[0] = phase_a & ANGLE_MASK;
        angle[1] = phase_b & ANGLE_MASK;
        for (int tone = 0; tone < 2; tone++) begin
            sin_w[tone] = tone_sine(angle[tone]);
            cos_w[tone] = tone_sine(angle[tone] + QUARTER_TURN);
        end
        for (int ch = 0; ch < 2; ch++) begin
            x = (ch == 0) ? left : right;
            sq = x * x;
            if (power_acc[ch] > POWER_LIMIT - sq) begin
                power_acc[ch] = POWER_LIMIT;
            end else begin
                power_acc[ch] = power_acc[ch] + sq;
            end
            for (int tone = 0; tone < 2; tone++) begin
                k = ch * 2 + tone;
                cos_acc[k] = clamp_add(cos_acc[k], x * cos_w[tone]);
                sin_acc[k] = clamp_add(sin_acc[k], x * sin_w[tone]);
            end
        end
        // counter sticks at full scale, phases wrap once per turn
        if (frames_mirror != '1) begin
            frames_mirror = frames_mirror + 1'b1;
        end
        phase_a = phase_a + step_a;
        phase_b = phase_b + step_b;

        tot.frames_seen = frames_mirror;
        tot.left_power  = power_acc[0][stla_pkg::POWER_W-1:0];
        tot.right_power = power_acc[1][stla_pkg::POWER_W-1:0];
        tot.left_cos_a  = cos_acc[0];
        tot.left_sin_a  = sin_acc[0];
        tot.left_cos_b  = cos_acc[1];
        tot.left_sin_b  = sin_acc[1];
        tot.right_cos_a = cos_acc[2];
        tot.right_sin_a = sin_acc[2];
        tot.right_cos_b = cos_acc[3];
        tot.right_sin_b = sin_acc[3];
        pending_totals.push_back(tot);
    endtask

    // One frame transfer; valid stays high for a following frame
    task automatic send_frame(input logic signed [stla_pkg::SAMPLE_W-1:0] left,
                              input logic signed [stla_pkg::SAMPLE_W-1:0] right);
        i_in_valid <= 1'b1;
        i_left_sample <= left;
        i_right_sample <= right;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        accumulate_frame(left, right);
    endtask

    task automatic write_step(input logic [stla_pkg::CFG_INDEX_W-1:0] index,
                              input logic [stla_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (index)
            stla_pkg::REG_TONE_STEP_A: step_a = data;
            stla_pkg::REG_TONE_STEP_B: step_b = data;
            default: ;
        endcase
    endtask

    // Stop offering frames and let every queued total come back
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_totals.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic signed [stla_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2, 3: return 24'($signed($urandom_range(0, 511)) - 256);
            4: return $urandom_range(0, 1) ? SAMPLE_MAX - 24'($urandom_range(0, 255))
                                           : SAMPLE_MIN + 24'($urandom_range(0, 255));
            default: return 24'($urandom());
        endcase
    endfunction

    function automatic logic [stla_pkg::CFG_DATA_W-1:0] pick_step();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 32'h8000_0000;
            3: return 32'($urandom_range(1, 64));
            default: return $urandom();
        endcase
    endfunction

    task automatic send_bursts(input int count, input bit with_gaps);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 24);
            for (int n = 0; n < burst && sent < count; n++) begin
                send_frame(pick_sample(), pick_sample());
                sent++;
            end
            gap = with_gaps ? $urandom_range(0, 6) : 0;
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Full-scale and bit-pattern frames at the reset tone steps
    task automatic test_directed_extremes();
        stall_mode = STALL_NONE;
        send_frame('0, '0);
        send_frame(SAMPLE_MAX, SAMPLE_MAX);
        send_frame(SAMPLE_MIN, SAMPLE_MIN);
        send_frame(SAMPLE_MAX, SAMPLE_MIN);
        send_frame(SAMPLE_MIN, SAMPLE_MAX);
        send_frame(24'sd1, -24'sd1);
        send_frame(-24'sd1, 24'sd1);
        send_frame(24'sh55_5555, 24'shAA_AAAA);
        send_frame(24'shAA_AAAA, 24'sh55_5555);
        send_frame(SAMPLE_MIN, '0);
        send_frame('0, SAMPLE_MAX);
        send_frame(24'sd123456, -24'sd654321);
        wait_idle();
    endtask

    // Step extremes, backward wrap and writes past the register map
    task automatic test_tone_steps();
        write_step(stla_pkg::REG_TONE_STEP_A, '0);
        write_step(stla_pkg::REG_TONE_STEP_B, '1);
        send_frame(SAMPLE_MAX, SAMPLE_MIN);
        send_frame(SAMPLE_MAX, SAMPLE_MAX);
        send_frame(SAMPLE_MIN, 24'sd4096);
        send_frame(-24'sd4096, SAMPLE_MAX);
        wait_idle();
        write_step(REG_SPARE_2, 32'h1234_5678);
        write_step(REG_SPARE_3, '1);
        send_frame(SAMPLE_MAX, SAMPLE_MIN);
        send_frame(SAMPLE_MIN, SAMPLE_MAX);
        send_frame(24'sd77, -24'sd77);
        wait_idle();
        write_step(stla_pkg::REG_TONE_STEP_A, 32'h8000_0000);
        write_step(stla_pkg::REG_TONE_STEP_B, QUARTER_TURN);
        send_frame(SAMPLE_MAX, SAMPLE_MAX);
        send_frame(SAMPLE_MAX, SAMPLE_MIN);
        send_frame(SAMPLE_MIN, SAMPLE_MAX);
        send_frame(SAMPLE_MIN, SAMPLE_MIN);
        wait_idle();
    endtask

    // Random tone steps per phase, random frames under varied flow control
    task automatic test_random_streams();
        for (int ph = 0; ph < 6; ph++) begin
            write_step(stla_pkg::REG_TONE_STEP_A, pick_step());
            write_step(stla_pkg::REG_TONE_STEP_B, pick_step());
            case (ph % 3)
                0: stall_mode = STALL_RANDOM;
                1: stall_mode = STALL_PATTERN;
                default: stall_mode = STALL_NONE;
            endcase
            send_bursts(300, ph != 2);
            wait_idle();
        end
    endtask

    // Receiver holds off long enough for the block to back up to its input
    task automatic test_output_holdoff();
        stall_mode = STALL_NONE;
        write_step(stla_pkg::REG_TONE_STEP_A, stla_pkg::STEP_A_RESET);
        write_step(stla_pkg::REG_TONE_STEP_B, stla_pkg::STEP_B_RESET);
        holdoff_len = 300;
        holdoff_asked++;
        send_bursts(60, 1'b0);
        stall_mode = STALL_RANDOM;
        send_bursts(40, 1'b1);
        wait_idle();
        stall_mode = STALL_NONE;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_extremes();
        test_tone_steps();
        test_random_streams();
        test_output_holdoff();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Receiver stall: pending hold-off first, then the selected pattern
    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 1;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (holdoff_left > 0) begin
            i_out_stall <= 1'b1;
            holdoff_left <= holdoff_left - 1;
        end else if (holdoff_taken != holdoff_asked) begin
            i_out_stall <= 1'b1;
            holdoff_taken <= holdoff_asked;
            holdoff_left <= holdoff_len;
        end else begin
            case (stall_mode)
                STALL_RANDOM: i_out_stall <= ($urandom_range(0, 99) < 35);
                STALL_PATTERN: i_out_stall <= ((stall_tick % 7) < 3);
                default: i_out_stall <= 1'b0;
            endcase
        end
    end

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            fail_count++;
        end
    endtask

    // Each output transfer is checked against the oldest pending totals
    always @(posedge i_clk) begin : check_totals
        t_totals want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_totals.size() == 0) begin
                $error("output transfer with no frame pending");
                fail_count++;
            end else begin
                want = pending_totals.pop_front();
                compare_field("frames_seen", 64'(want.frames_seen), 64'(o_frames_seen));
                compare_field("left_power", 64'(want.left_power), 64'(o_left_power));
                compare_field("right_power", 64'(want.right_power), 64'(o_right_power));
                compare_field("left_cos_a", want.left_cos_a, o_left_cos_a);
                compare_field("left_sin_a", want.left_sin_a, o_left_sin_a);
                compare_field("left_cos_b", want.left_cos_b, o_left_cos_b);
                compare_field("left_sin_b", want.left_sin_b, o_left_sin_b);
                compare_field("right_cos_a", want.right_cos_a, o_right_cos_a);
                compare_field("right_sin_a", want.right_sin_a, o_right_sin_a);
                compare_field("right_cos_b", want.right_cos_b, o_right_cos_b);
                compare_field("right_sin_b", want.right_sin_b, o_right_sin_b);
            end
        end
    end

endmodule
